### sv/assert_macros.svh
// Assertion helpers for the predicate picker.
// Each macro takes a label, the clock, the active-low reset and the two sides.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define SPP_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication check failed");

// Next-cycle implication
`define SPP_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`else

`define SPP_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SPP_ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

### sv/spp_pkg.sv
package spp_pkg;

	// Table geometry and field widths
	localparam int ENTRIES = 32;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 31;
	localparam int MASK_W  = 32;
	localparam int PROD_W  = 2 * CNT_W;
	localparam int ROW_W   = 2 * CNT_W;

	// Request kinds
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_SELECTED = 2'd0;
	localparam logic [1:0] ST_STORED   = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  op_index;
		logic [CNT_W-1:0]  rows_before;
		logic [CNT_W-1:0]  rows_after;
		logic [MASK_W-1:0] done_mask;
		logic              batch_last;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] selected_index;
		logic             found;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REC,
		S_RD,
		S_MUL,
		S_CMP,
		S_FIN
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic rec_commit;
		logic rd_first;
		logic mul;
		logic cmp;
		logic fin;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_select;
		logic limit_zero;
		logic last;
	} dp_status_t;

endpackage

### sv/spp_ram.sv
module spp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/spp_ctrl.sv
module spp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  spp_pkg::dp_status_t    dp_status,
	output spp_pkg::ctrl_cmd_t     cmd,
	output logic                   busy
);

	spp_pkg::state_t state_q;
	spp_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			spp_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!dp_status.in_select) begin
						state_d = spp_pkg::S_REC;
					end else if (dp_status.limit_zero) begin
						state_d = spp_pkg::S_FIN;
					end else begin
						state_d = spp_pkg::S_RD;
					end
				end
			end
			spp_pkg::S_REC: begin
				cmd.rec_commit = 1'b1;
				state_d = spp_pkg::S_IDLE;
			end
			spp_pkg::S_RD: begin
				cmd.rd_first = 1'b1;
				state_d = spp_pkg::S_MUL;
			end
			spp_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = spp_pkg::S_CMP;
			end
			spp_pkg::S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = dp_status.last ? spp_pkg::S_FIN : spp_pkg::S_MUL;
			end
			spp_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				state_d = spp_pkg::S_IDLE;
			end
			default: begin
				state_d = spp_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != spp_pkg::S_IDLE);

endmodule

### sv/spp_dp.sv
module spp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spp_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [spp_pkg::IDX_W-1:0]     cfg_data,
	input  spp_pkg::ctrl_cmd_t            cmd,
	output spp_pkg::dp_status_t           dp_status,
	output spp_pkg::rsp_t                 result,
	output logic                          done
);

	spp_pkg::req_t                   req_q;
	logic [spp_pkg::IDX_W-1:0]       active_q;
	logic [spp_pkg::ENTRIES-1:0]     valid_q;
	logic [spp_pkg::IDX_W-1:0]       idx_q;
	logic                            have_q;
	logic [spp_pkg::IDX_W-1:0]       best_q;
	logic [spp_pkg::CNT_W-1:0]       bout_q;
	logic [spp_pkg::CNT_W-1:0]       bin_q;
	logic [spp_pkg::PROD_W-1:0]      p_cand_s1;
	logic [spp_pkg::PROD_W-1:0]      p_best_s1;
	logic [spp_pkg::CNT_W-1:0]       cand_o_s1;
	logic [spp_pkg::CNT_W-1:0]       cand_n_s1;
	logic                            elig_s1;
	spp_pkg::rsp_t                   result_q;
	logic                            done_q;

	logic                            rec_ok;
	logic [spp_pkg::IDX_W-1:0]       raddr;
	logic [spp_pkg::ROW_W-1:0]       wdata;
	logic [spp_pkg::ROW_W-1:0]       rdata;
	logic [spp_pkg::CNT_W-1:0]       ent_o;
	logic [spp_pkg::CNT_W-1:0]       ent_n;
	logic                            take;

	// Status toward the controller
	assign dp_status.in_select  = (req.req_type == spp_pkg::REQ_SELECT);
	assign dp_status.limit_zero = (active_q == '0);
	assign dp_status.last       = (idx_q == (active_q - spp_pkg::IDX_W'(1)));

	// Observation check: nonzero input rows and no growth
	assign rec_ok = (req_q.rows_before != '0) && (req_q.rows_after <= req_q.rows_before);

	// Table row: rows-out in the upper half, rows-in in the lower half
	assign wdata = {req_q.rows_after, req_q.rows_before};
	assign raddr = cmd.cmp ? (idx_q + spp_pkg::IDX_W'(1)) : idx_q;

	spp_ram #(
		.WIDTH(spp_pkg::ROW_W),
		.DEPTH(spp_pkg::ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (cmd.rec_commit && rec_ok),
		.waddr(req_q.op_index),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Unwritten entries read as selectivity zero over one
	assign ent_o = valid_q[idx_q] ? rdata[spp_pkg::ROW_W-1:spp_pkg::CNT_W] : '0;
	assign ent_n = valid_q[idx_q] ? rdata[spp_pkg::CNT_W-1:0] : spp_pkg::CNT_W'(1);

	// Strictly smaller ratio replaces the best; first eligible always taken
	assign take = elig_s1 && (!have_q || (p_cand_s1 < p_best_s1));

	// Configuration register and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			valid_q  <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (cmd.rec_commit && rec_ok) begin
				valid_q[req_q.op_index] <= 1'b1;
			end
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Scan control: index and running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			have_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q  <= '0;
			have_q <= 1'b0;
		end else if (cmd.cmp) begin
			idx_q <= idx_q + spp_pkg::IDX_W'(1);
			if (take) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && take) begin
			best_q <= idx_q;
			bout_q <= cand_o_s1;
			bin_q  <= cand_n_s1;
		end
	end

	// Cross-multiply the candidate against the running best
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_cand_s1 <= spp_pkg::PROD_W'(ent_o) * spp_pkg::PROD_W'(bin_q);
			p_best_s1 <= spp_pkg::PROD_W'(bout_q) * spp_pkg::PROD_W'(ent_n);
			cand_o_s1 <= ent_o;
			cand_n_s1 <= ent_n;
			elig_s1   <= !req_q.done_mask[idx_q];
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.rec_commit || cmd.fin;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.rec_commit) begin
			result_q.status         <= rec_ok ? spp_pkg::ST_STORED : spp_pkg::ST_REJECTED;
			result_q.selected_index <= '0;
			result_q.found          <= 1'b0;
		end else if (cmd.fin) begin
			result_q.status         <= spp_pkg::ST_SELECTED;
			result_q.selected_index <= have_q ? best_q : '0;
			result_q.found          <= have_q;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

### sv/selectivity_predicate_picker_core.sv
// Predicate picker: keeps the last rows-out/rows-in pair per predicate and
// returns the unapplied predicate below active_count with the lowest
// selectivity (exact cross-multiply compare, lowest index on ties). A request
// is taken when start is high and busy is low; its one result shows on result
// for a single cycle with done high, and must be taken then since the receiver
// cannot stall. A record transaction passes through S_REC, then the result
// register. A select transaction scans the first active_count entries: S_RD
// primes the table read, each entry passes through a multiply step (S_MUL)
// then a compare step (S_CMP), since every comparison is against the best
// entry that the previous one left, and S_FIN registers the pick. A new
// request may be taken in the cycle that done is high. active_count is
// written through cfg_valid/cfg_ready, by the user only while no request
// is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module selectivity_predicate_picker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  spp_pkg::req_t                 req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [spp_pkg::IDX_W-1:0]     cfg_data,
	output spp_pkg::rsp_t                 result,
	output logic                          done
);

	spp_pkg::ctrl_cmd_t  cmd;
	spp_pkg::dp_status_t dp_status;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	spp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dp_status(dp_status),
		.cmd      (cmd),
		.busy     (busy)
	);

	spp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.dp_status(dp_status),
		.result   (result),
		.done     (done)
	);

	// A taken transaction occupies the block in the next cycle
	`SPP_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	// A result strobe lasts one cycle
	`SPP_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)
	// Results appear only once the block is free again
	`SPP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	// No pick means index zero
	`SPP_ASSERT_IMP(a_nofind_zero, clk, arst_n, done && !result.found, result.selected_index == '0)

endmodule
